[rtl/hrfp_pkg.sv]
// hrfp_pkg: shared types, token codes and header-name tables for the http request parser
// no dependencies; imported by hrfp_core, hrfp_obuf and http_request_field_parser
`default_nettype none
package hrfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] field_length;
    logic [30:0] number_value;
    logic        run_last;
  } out_t;

  // results produced by one byte, item 0 goes out first
  typedef struct packed {
    logic [1:0]     cnt;
    out_t [2:0]     item;
  } burst_t;

  typedef enum logic [3:0] {
    PH_METHOD, PH_PATH, PH_KEYSTART, PH_KEY, PH_VALUE, PH_LINESKIP, PH_HNAME,
    PH_HCR, PH_HSKIP, PH_HWS, PH_HNUM, PH_HSTR, PH_BODY, PH_HALT
  } phase_e;

  localparam logic [3:0] TK_METHOD = 4'd0;
  localparam logic [3:0] TK_PATH   = 4'd1;
  localparam logic [3:0] TK_KEY    = 4'd2;
  localparam logic [3:0] TK_VALUE  = 4'd3;
  localparam logic [3:0] TK_LENGTH = 4'd4;
  localparam logic [3:0] TK_HDREND = 4'd8;
  localparam logic [3:0] TK_DONE   = 4'd9;
  localparam logic [3:0] TK_ERROR  = 4'd10;

  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
  localparam logic [4:0]  MAX_PARAMS_RST = 5'd16;

  localparam logic [8*15-1:0] HN_CLEN = "Content-Length:";
  localparam logic [8*13-1:0] HN_CTYP = "Content-Type:";
  localparam logic [8*14-1:0] HN_AUTH = "Authorization:";
  localparam logic [8*5-1:0]  HN_HOST = "Host:";

  function automatic logic [4:0] hlen(input logic [1:0] k);
    logic [4:0] l;
    case (k)
      2'd0: l = 5'd15;
      2'd1: l = 5'd13;
      2'd2: l = 5'd14;
      default: l = 5'd5;
    endcase
    return l;
  endfunction

  // character m of header name k; caller keeps m below the name length
  function automatic logic [7:0] hchar(input logic [1:0] k, input logic [3:0] m);
    logic [7:0] c;
    case (k)
      2'd0: c = HN_CLEN[8*(14-int'(m)) +: 8];
      2'd1: c = (m < 4'd13) ? HN_CTYP[8*(12-int'(m)) +: 8] : 8'd0;
      2'd2: c = (m < 4'd14) ? HN_AUTH[8*(13-int'(m)) +: 8] : 8'd0;
      default: c = (m < 4'd5) ? HN_HOST[8*(4-int'(m)) +: 8] : 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] first_cand(input logic [3:0] c);
    logic [1:0] k;
    if (c[0]) k = 2'd0;
    else if (c[1]) k = 2'd1;
    else if (c[2]) k = 2'd2;
    else if (c[3]) k = 2'd3;
    else k = 2'd0;
    return k;
  endfunction

  function automatic out_t mk(input logic [3:0] kind, input logic [31:0] st,
                              input logic [31:0] len, input logic [30:0] num);
    out_t o;
    o.token_kind   = kind;
    o.start_offset = st[15:0];
    o.field_length = len[15:0];
    o.number_value = num;
    o.run_last     = 1'b0;
    return o;
  endfunction

endpackage
`default_nettype wire

[rtl/hrfp_core.sv]
// hrfp_core: parser state registers and the per-byte next-state and result logic
// depends on hrfp_pkg
`default_nettype none
module hrfp_core #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_PARAMS  = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            take_i,
  input  wire hrfp_pkg::in_t   in_i,
  input  wire logic [4:0]      max_params_i,
  output hrfp_pkg::burst_t     burst_o
);
  import hrfp_pkg::*;

  localparam int OB  = OFFSET_BITS;
  localparam int PCW = $clog2(MAX_PARAMS + 1);
  localparam int LW  = (PCW > 5) ? PCW : 5;
  localparam logic [LW-1:0] MAXP = LW'(MAX_PARAMS);

  phase_e        ph_q, ph_d;
  logic [OB-1:0] pos_q, pos_d, ts_q, ts_d, heo_q, heo_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic [3:0]    cand_q, cand_d, hmi_q, hmi_d;
  logic [30:0]   acc_q, acc_d, br_q, br_d;

  always_comb begin
    logic [7:0]    b;
    logic [OB-1:0] pos, ets, e, pos1;
    phase_e        eph;
    logic [LW-1:0] lim;
    logic [3:0]    nc;
    logic [1:0]    k;
    logic [1:0]    n;
    logic [34:0]   sum;
    logic [30:0]   brn;
    out_t [2:0]    r;
    b    = in_i.data_byte;
    pos  = pos_q;
    pos1 = pos_q + 1'b1;
    ets  = ts_q;
    eph  = ph_q;
    lim  = (LW'(max_params_i) < MAXP) ? LW'(max_params_i) : MAXP;
    nc   = '0;
    k    = '0;
    n    = '0;
    sum  = '0;
    brn  = '0;
    r    = '0;
    e    = (b == 8'h0A) ? pos1 : pos;
    ph_d = ph_q; pos_d = pos_q; heo_d = heo_q; pc_d = pc_q;
    cand_d = cand_q; hmi_d = hmi_q; acc_d = acc_q; br_d = br_q;

    // phases that hand the same byte on to the next phase
    if (ph_q == PH_KEYSTART) begin
      if (LW'(pc_q) >= lim || b == 8'h20) eph = PH_LINESKIP;
      else begin
        eph = PH_KEY;
        ets = pos;
      end
    end else if (ph_q == PH_HWS && b != 8'h20 && b != 8'h09) begin
      ets = pos;
      eph = cand_q[0] ? PH_HNUM : PH_HSTR;
    end
    ph_d = eph;
    ts_d = ets;

    case (eph)
      PH_METHOD, PH_PATH: begin
        if (eph == PH_METHOD && b == 8'h20) begin
          r[n] = mk(TK_METHOD, 32'(ets), 32'(pos - ets), '0); n = n + 1'b1;
          ts_d = pos1;
          ph_d = PH_PATH;
        end else if (eph == PH_PATH && (b == 8'h20 || b == 8'h3F)) begin
          r[n] = mk(TK_PATH, 32'(ets), 32'(pos - ets), '0); n = n + 1'b1;
          ph_d = (b == 8'h3F) ? PH_KEYSTART : PH_LINESKIP;
        end else if (b == 8'h0A) begin
          r[n] = mk(TK_ERROR, 32'(pos), '0, '0); n = n + 1'b1;
          ph_d = PH_HALT;
        end
      end
      PH_KEY, PH_VALUE: begin
        if (eph == PH_KEY && b == 8'h3D) begin
          r[n] = mk(TK_KEY, 32'(ets), 32'(pos - ets), '0); n = n + 1'b1;
          ts_d = pos1;
          ph_d = PH_VALUE;
        end else if (b == 8'h26 || b == 8'h20 || b == 8'h0A) begin
          if (eph == PH_KEY) begin
            r[n] = mk(TK_KEY, 32'(ets), 32'(e - ets), '0); n = n + 1'b1;
            r[n] = mk(TK_VALUE, 32'(e), '0, '0); n = n + 1'b1;
          end else begin
            r[n] = mk(TK_VALUE, 32'(ets), 32'(e - ets), '0); n = n + 1'b1;
          end
          pc_d = pc_q + 1'b1;
          if (b == 8'h26) ph_d = PH_KEYSTART;
          else if (b == 8'h20) ph_d = PH_LINESKIP;
          else begin
            ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
          end
        end
      end
      PH_LINESKIP: begin
        if (b == 8'h0A) begin
          ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
        end
      end
      PH_HNAME: begin
        if (hmi_q == 4'd0 && b == 8'h0D) ph_d = PH_HCR;
        else begin
          for (int i = 0; i < 4; i++) begin
            nc[i] = cand_q[i] && ({1'b0, hmi_q} < hlen(2'(i))) && (hchar(2'(i), hmi_q) == b);
          end
          cand_d = nc;
          if (nc == 4'd0) begin
            if (b == 8'h0A) begin
              ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
            end else ph_d = PH_HSKIP;
          end else begin
            hmi_d = hmi_q + 1'b1;
            k = first_cand(nc);
            if (hlen(k) == {1'b0, hmi_q} + 5'd1) begin
              cand_d = 4'b0001 << k;
              if (k == 2'd0) acc_d = '0;
              ph_d = PH_HWS;
            end
          end
        end
      end
      PH_HCR: begin
        if (b == 8'h0A) begin
          r[n] = mk(TK_HDREND, 32'(pos - 1'b1), 32'd2, '0); n = n + 1'b1;
          heo_d = pos1;
          br_d  = acc_q;
          if (acc_q == '0) begin
            r[n] = mk(TK_DONE, 32'(pos1), 32'(pos1), '0); n = n + 1'b1;
            ph_d = PH_HALT;
          end else ph_d = PH_BODY;
        end else ph_d = PH_HSKIP;
      end
      PH_HSKIP: begin
        if (b == 8'h0A) begin
          ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
        end else ph_d = PH_HSKIP;
      end
      PH_HNUM: begin
        if (b >= 8'h30 && b <= 8'h39) begin
          sum = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + 35'(b - 8'h30);
          acc_d = (sum > 35'(LEN_MAX)) ? LEN_MAX : sum[30:0];
        end else begin
          r[n] = mk(TK_LENGTH, 32'(ets), 32'(pos - ets), acc_q); n = n + 1'b1;
          if (b == 8'h0A) begin
            ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
          end else ph_d = PH_HSKIP;
        end
      end
      PH_HSTR: begin
        if (b == 8'h0D || b == 8'h0A) begin
          r[n] = mk(TK_LENGTH + 4'(first_cand(cand_q)), 32'(ets), 32'(pos - ets), '0);
          n = n + 1'b1;
          if (b == 8'h0A) begin
            ph_d = PH_HNAME; cand_d = 4'hF; hmi_d = '0;
          end else ph_d = PH_HSKIP;
        end
      end
      PH_BODY: begin
        brn  = (br_q != '0) ? br_q - 1'b1 : br_q;
        br_d = brn;
        if (brn == '0) begin
          r[n] = mk(TK_DONE, 32'(heo_q), 32'(pos1), '0); n = n + 1'b1;
          ph_d = PH_HALT;
        end
      end
      default: ;
    endcase

    if (in_i.final_byte) begin
      if (ph_d != PH_HALT) begin
        r[n] = mk(TK_ERROR, 32'(pos), '0, '0); n = n + 1'b1;
      end
      ph_d = PH_METHOD; pos_d = '0; ts_d = '0; pc_d = '0; cand_d = 4'hF;
      hmi_d = '0; acc_d = '0; br_d = '0; heo_d = '0;
    end else begin
      pos_d = pos1;
    end
    if (n != 2'd0) r[n - 1'b1].run_last = 1'b1;
    burst_o.cnt  = n;
    burst_o.item = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_METHOD; pos_q <= '0; ts_q <= '0; heo_q <= '0; pc_q <= '0;
      cand_q <= 4'hF; hmi_q <= '0; acc_q <= '0; br_q <= '0;
    end else if (take_i) begin
      ph_q <= ph_d; pos_q <= pos_d; ts_q <= ts_d; heo_q <= heo_d; pc_q <= pc_d;
      cand_q <= cand_d; hmi_q <= hmi_d; acc_q <= acc_d; br_q <= br_d;
    end
  end

endmodule
`default_nettype wire

[rtl/hrfp_obuf.sv]
// hrfp_obuf: result register holding the up to three results of one byte
// depends on hrfp_pkg
`default_nettype none
module hrfp_obuf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire hrfp_pkg::burst_t burst_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output hrfp_pkg::out_t        data_o
);
  import hrfp_pkg::*;

  logic [1:0]  cnt_q, cnt_d;
  out_t [2:0]  ent_q, ent_d;

  // room when the buffer is empty or drains completely in this cycle
  assign room_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && ready_i);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[0];

  always_comb begin
    cnt_d = cnt_q;
    ent_d = ent_q;
    if (valid_o && ready_i) begin
      cnt_d = cnt_q - 1'b1;
      ent_d = {ent_q[2], ent_q[2:1]};
    end
    if (load_i) begin
      cnt_d = burst_i.cnt;
      ent_d = burst_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule
`default_nettype wire

[rtl/http_request_field_parser.sv]
// http_request_field_parser: top level, config register, parser core and result buffer
// depends on hrfp_pkg, hrfp_core, hrfp_obuf
// One request byte per cycle while the result register has room. Each byte updates the
// parser state in the cycle it is taken and loads its zero to three results into a result
// register, which sends one result per cycle while out_ready_i is high. A byte is taken
// whenever that register is empty or empties in the same cycle, so bytes with at most one
// result run at one per cycle while results are accepted; a byte with more results holds
// the input until they drain. After a final byte the parser restarts; max_params is kept.
`default_nettype none
module http_request_field_parser #(
  parameter int OFFSET_BITS = 16,
  parameter int MAX_PARAMS  = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire hrfp_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output hrfp_pkg::out_t      out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic [4:0]     cfg_wdata_i
);
  import hrfp_pkg::*;

  logic [4:0] max_params_q;
  logic       take;
  burst_t     burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_params_q <= MAX_PARAMS_RST;
    else if (cfg_we_i) max_params_q <= cfg_wdata_i;
  end

  assign take = in_valid_i && in_ready_o;

  hrfp_core #(.OFFSET_BITS(OFFSET_BITS), .MAX_PARAMS(MAX_PARAMS)) u_core (
    .clk_i, .rst_ni, .take_i(take), .in_i(in_data_i),
    .max_params_i(max_params_q), .burst_o(burst)
  );

  hrfp_obuf u_obuf (
    .clk_i, .rst_ni, .load_i(take), .burst_i(burst), .room_o(in_ready_o),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .data_o(out_data_o)
  );

  a_ready_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while results remain");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind != TK_LENGTH |-> out_data_o.number_value == '0)
    else $error("number on non-length record");

endmodule
`default_nettype wire
